FILE: hw/rtl/mcu13_pkg.sv
// Shared types and constants for the 13-bit instruction decoder.
// Holds the decoded result record, instruction numbers and fixed-opcode map.
// No dependencies.
package mcu13_pkg;

    localparam int WORD_W = 13;
    localparam int ID_W   = 7;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic       valid_res;
        logic [6:0] instr_id;
        logic [5:0] mem_addr;
        logic [4:0] io_addr;
        logic [2:0] bit_index;
        logic [7:0] immediate;
        logic [9:0] jump_target;
    } dec_res_t;

    localparam word_t WORD_ALL_ONES = 13'h1FFF;

    localparam logic [ID_W-1:0] ID_XOR_IO_A = 7'd27;
    localparam logic [ID_W-1:0] ID_STT16    = 7'd30;
    localparam logic [ID_W-1:0] ID_MEM_ALU  = 7'd34;
    localparam logic [ID_W-1:0] ID_RET_K    = 7'd65;
    localparam logic [ID_W-1:0] ID_ADD_K    = 7'd66;
    localparam logic [ID_W-1:0] ID_T0SN_M   = 7'd73;
    localparam logic [ID_W-1:0] ID_T0SN_IO  = 7'd77;
    localparam logic [ID_W-1:0] ID_CALL     = 7'd81;
    localparam logic [ID_W-1:0] ID_GOTO     = 7'd82;

    localparam logic [5:0] MEM_ALU_BASE    = 6'h10;
    localparam logic [5:0] MEM_ALU_UNIMPL  = 6'h1F;
    localparam logic [2:0] IMM_GRP_UNIMPL  = 3'd3;

    // Fixed opcodes 0x00..0x3F: {known, id}.
    function automatic logic [ID_W:0] fixed_id(input logic [5:0] op);
        logic [ID_W:0] r;
        r = '0;
        unique case (op)
            6'h00: r = {1'b1, 7'd0};
            6'h06: r = {1'b1, 7'd1};
            6'h07: r = {1'b1, 7'd2};
            6'h10: r = {1'b1, 7'd3};
            6'h11: r = {1'b1, 7'd4};
            6'h12: r = {1'b1, 7'd5};
            6'h13: r = {1'b1, 7'd6};
            6'h17: r = {1'b1, 7'd7};
            6'h18: r = {1'b1, 7'd8};
            6'h19: r = {1'b1, 7'd9};
            6'h1A: r = {1'b1, 7'd10};
            6'h1B: r = {1'b1, 7'd11};
            6'h1C: r = {1'b1, 7'd12};
            6'h1D: r = {1'b1, 7'd13};
            6'h1E: r = {1'b1, 7'd14};
            6'h20: r = {1'b1, 7'd15};
            6'h30: r = {1'b1, 7'd16};
            6'h32: r = {1'b1, 7'd17};
            6'h33: r = {1'b1, 7'd18};
            6'h35: r = {1'b1, 7'd19};
            6'h36: r = {1'b1, 7'd20};
            6'h37: r = {1'b1, 7'd21};
            6'h38: r = {1'b1, 7'd22};
            6'h39: r = {1'b1, 7'd23};
            6'h3A: r = {1'b1, 7'd24};
            6'h3B: r = {1'b1, 7'd25};
            6'h3C: r = {1'b1, 7'd26};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/mcu13_dec.sv
// Combinational decode of one instruction word into id and operand fields.
// Depends on mcu13_pkg.
module mcu13_dec (
    input  mcu13_pkg::word_t    word,
    output mcu13_pkg::dec_res_t res
);
    import mcu13_pkg::*;

    logic [ID_W:0] fx;
    logic [5:0]    alu_grp;
    logic [2:0]    imm_grp;

    assign fx      = fixed_id(word[5:0]);
    assign alu_grp = word[11:6] - MEM_ALU_BASE;
    assign imm_grp = word[10:8];

    always_comb begin
        res = '0;
        if (word == WORD_ALL_ONES) begin
            res = '0;
        end else if (word <= 13'h003F) begin
            res.valid_res = fx[ID_W];
            res.instr_id  = fx[ID_W-1:0];
        end else if (word >= 13'h0060 && word <= 13'h00BF) begin
            res.valid_res = 1'b1;
            res.instr_id  = ID_XOR_IO_A + 7'(word[7:5] - 3'd3);
            res.io_addr   = word[4:0];
        end else if (word >= 13'h00C0 && word <= 13'h00FF) begin
            res.valid_res = 1'b1;
            res.instr_id  = ID_STT16 + {5'd0, word[5], word[0]};
            res.mem_addr  = {1'b0, word[4:1], 1'b0};
        end else if (word >= 13'h0400 && word <= 13'h0BFF) begin
            if (alu_grp != MEM_ALU_UNIMPL) begin
                res.valid_res = 1'b1;
                res.instr_id  = ID_MEM_ALU + {1'b0, alu_grp};
                res.mem_addr  = word[5:0];
            end
        end else if (word[12:8] == 5'h01) begin
            res.valid_res = 1'b1;
            res.instr_id  = ID_RET_K;
            res.immediate = word[7:0];
        end else if (word[12:11] == 2'b10) begin
            if (imm_grp != IMM_GRP_UNIMPL) begin
                res.valid_res = 1'b1;
                res.instr_id  = (imm_grp < IMM_GRP_UNIMPL) ?
                                ID_ADD_K + {4'd0, imm_grp} :
                                ID_RET_K + {4'd0, imm_grp};
                res.immediate = word[7:0];
            end
        end else if (word[12:9] == 4'b0001) begin
            res.valid_res = 1'b1;
            res.instr_id  = ID_T0SN_M + {5'd0, word[8], word[0]};
            res.mem_addr  = {1'b0, word[4:1], 1'b0};
            res.bit_index = word[7:5];
        end else if (word >= 13'h0C00 && word <= 13'h0FFF) begin
            res.valid_res = 1'b1;
            res.instr_id  = ID_T0SN_IO + {5'd0, word[9:8]};
            res.io_addr   = word[4:0];
            res.bit_index = word[7:5];
        end else if (word[12:11] == 2'b11) begin
            res.valid_res   = 1'b1;
            res.instr_id    = word[10] ? ID_CALL : ID_GOTO;
            res.jump_target = word[9:0];
        end
    end

endmodule

FILE: hw/rtl/mcu13_instruction_decoder.sv
// Top level of the 13-bit instruction decoder: input stage, decode, result stage.
// Depends on mcu13_pkg and mcu13_dec.
//
// Usage:
//   Input channel s_valid/s_ready carries one instruction word per beat
//   (s_instr_word). Result channel m_valid/m_ready carries one decoded beat per
//   input beat: m_valid_res, m_instr_id and the operand fields. Unknown words
//   (all ones, unlisted fixed opcodes, unimplemented compare forms) come out
//   with m_valid_res low and every field zero.
//   Path: a word accepted into the input register is decoded and presented on the result
//   channel once the result register takes it (input register, then result register).
//   Throughput: one word per cycle while m_ready is high; the decode is one pass
//   of logic between the input register and the result register.
//   Stall: while the result is held by m_ready low, the input stage still takes
//   one more word; s_ready drops only when both stages are full.
//   Reset: aresetn low empties both stages synchronously; no result is lost
//   or repeated after reset since nothing is in flight.
module mcu13_instruction_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mcu13_pkg::word_t   s_instr_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_valid_res,
    output logic [6:0]         m_instr_id,
    output logic [5:0]         m_mem_addr,
    output logic [4:0]         m_io_addr,
    output logic [2:0]         m_bit_index,
    output logic [7:0]         m_immediate,
    output logic [9:0]         m_jump_target
);
    import mcu13_pkg::*;

    logic     in_v_reg;
    word_t    in_word_reg;
    logic     out_v_reg;
    dec_res_t out_res_reg;
    dec_res_t dec_res;
    logic     adv;

    assign adv     = !out_v_reg || m_ready;
    assign s_ready = !in_v_reg || adv;

    mcu13_dec u_dec (
        .word (in_word_reg),
        .res  (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_v_reg <= s_valid;
            end
            if (adv) begin
                out_v_reg <= in_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_instr_word;
        end
        if (adv && in_v_reg) begin
            out_res_reg <= dec_res;
        end
    end

    assign m_valid       = out_v_reg;
    assign m_valid_res   = out_res_reg.valid_res;
    assign m_instr_id    = out_res_reg.instr_id;
    assign m_mem_addr    = out_res_reg.mem_addr;
    assign m_io_addr     = out_res_reg.io_addr;
    assign m_bit_index   = out_res_reg.bit_index;
    assign m_immediate   = out_res_reg.immediate;
    assign m_jump_target = out_res_reg.jump_target;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_instr_id == '0 && m_mem_addr == '0 &&
        m_io_addr == '0 && m_bit_index == '0 && m_immediate == '0 &&
        m_jump_target == '0)
        else $error("invalid result carries nonzero fields");

    a_id_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_instr_id <= ID_GOTO)
        else $error("instruction id out of range");

    a_target_only_jump: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_jump_target != '0 |-> m_instr_id == ID_CALL ||
        m_instr_id == ID_GOTO)
        else $error("jump target on a non-jump instruction");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_v_reg && !adv |=> in_v_reg && $stable(in_word_reg))
        else $error("input stage dropped a word while blocked");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_v_reg |-> s_ready)
        else $error("input not ready with empty result stage");

endmodule

FILE: bench/mcu13_instruction_decoder_tb.sv
// Self-checking bench for mcu13_instruction_decoder: directed table, then random words.
// Decoded beats are compared field by field against the table's expected result or a local decode function.
// Depends on mcu13_pkg and the decoder RTL.
module mcu13_instruction_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcu13_pkg::*;

    localparam int NUM_RANDOM    = 1150;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_AT_BEAT  = 400;
    localparam int HOLD_CYCLES   = 80;
    localparam int PAUSE_AT_WORD = 600;

    localparam logic [ID_W-1:0] ID_NOP = 7'd0;

    // Known fixed opcodes 0x00..0x3F; the id is the count of known codes below.
    localparam logic [63:0] FIXED_OPCODE_MAP = 64'h1FED0001_7F8F00C1;

    localparam word_t FIXED_LAST     = 13'h003F;
    localparam word_t IO_MOVE_FIRST  = 13'h0060;
    localparam word_t IO_MOVE_LAST   = 13'h00BF;
    localparam word_t WORD_ACC_FIRST = 13'h00C0;
    localparam word_t WORD_ACC_LAST  = 13'h00FF;
    localparam word_t RET_K_BASE     = 13'h0100;
    localparam word_t MEM_BIT_BASE   = 13'h0200;
    localparam word_t MEM_ALU_FIRST  = 13'h0400;
    localparam word_t MEM_ALU_LAST   = 13'h0BFF;
    localparam word_t IO_BIT_FIRST   = 13'h0C00;
    localparam word_t IO_BIT_LAST    = 13'h0FFF;
    localparam word_t IMM_BASE       = 13'h1000;
    localparam word_t JUMP_BASE      = 13'h1800;

    localparam dec_res_t NO_INSTR = '0;

    typedef enum int {
        GRP_FIXED, GRP_IO_MOVE, GRP_WORD_ACC, GRP_MEM_ALU, GRP_RET_K,
        GRP_IMM, GRP_MEM_BIT, GRP_IO_BIT, GRP_JUMP, GRP_ANY
    } word_group_e;

    typedef struct packed {
        word_t    word;
        logic     typed;
        dec_res_t want;
    } dir_row_t;

    typedef struct packed {
        word_t    word;
        dec_res_t want;
    } decode_due_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    word_t       s_instr_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_valid_res;
    logic [6:0]  m_instr_id;
    logic [5:0]  m_mem_addr;
    logic [4:0]  m_io_addr;
    logic [2:0]  m_bit_index;
    logic [7:0]  m_immediate;
    logic [9:0]  m_jump_target;

    decode_due_t decode_due[$];
    int          errors = 0;
    int          idle_cycles = 0;

    mcu13_instruction_decoder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_instr_word  (s_instr_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_valid_res   (m_valid_res),
        .m_instr_id    (m_instr_id),
        .m_mem_addr    (m_mem_addr),
        .m_io_addr     (m_io_addr),
        .m_bit_index   (m_bit_index),
        .m_immediate   (m_immediate),
        .m_jump_target (m_jump_target)
    );

    always #6 aclk = ~aclk;

    function automatic dec_res_t decode_word(input word_t w);
        dec_res_t   r;
        logic [5:0] grp;
        logic [2:0] imm_grp;
        r = NO_INSTR;
        if (w == WORD_ALL_ONES) begin
            r = NO_INSTR;
        end else if (w <= FIXED_LAST) begin
            if (FIXED_OPCODE_MAP[w[5:0]]) begin
                r.valid_res = 1'b1;
                r.instr_id  = 7'($countones(FIXED_OPCODE_MAP & ((64'd1 << w[5:0]) - 64'd1)));
            end
        end else if (w >= IO_MOVE_FIRST && w <= IO_MOVE_LAST) begin
            r.valid_res = 1'b1;
            r.instr_id  = ID_XOR_IO_A + 7'((w - IO_MOVE_FIRST) >> 5);
            r.io_addr   = w[4:0];
        end else if (w >= WORD_ACC_FIRST && w <= WORD_ACC_LAST) begin
            r.valid_res = 1'b1;
            r.instr_id  = ID_STT16 + 7'({w[5], w[0]});
            r.mem_addr  = {1'b0, w[4:1], 1'b0};
        end else if (w >= MEM_ALU_FIRST && w <= MEM_ALU_LAST) begin
            grp = w[11:6] - MEM_ALU_BASE;
            if (grp != MEM_ALU_UNIMPL) begin
                r.valid_res = 1'b1;
                r.instr_id  = ID_MEM_ALU + 7'(grp);
                r.mem_addr  = w[5:0];
            end
        end else if (w[12:8] == RET_K_BASE[12:8]) begin
            r.valid_res = 1'b1;
            r.instr_id  = ID_RET_K;
            r.immediate = w[7:0];
        end else if (w[12:11] == IMM_BASE[12:11]) begin
            imm_grp = w[10:8];
            if (imm_grp != IMM_GRP_UNIMPL) begin
                r.valid_res = 1'b1;
                r.instr_id  = (imm_grp < IMM_GRP_UNIMPL) ? ID_ADD_K + 7'(imm_grp)
                                                         : ID_RET_K + 7'(imm_grp);
                r.immediate = w[7:0];
            end
        end else if (w[12:9] == MEM_BIT_BASE[12:9]) begin
            r.valid_res = 1'b1;
            r.instr_id  = ID_T0SN_M + 7'({w[8], w[0]});
            r.mem_addr  = {1'b0, w[4:1], 1'b0};
            r.bit_index = w[7:5];
        end else if (w >= IO_BIT_FIRST && w <= IO_BIT_LAST) begin
            r.valid_res = 1'b1;
            r.instr_id  = ID_T0SN_IO + 7'(w[9:8]);
            r.io_addr   = w[4:0];
            r.bit_index = w[7:5];
        end else if (w[12:11] == JUMP_BASE[12:11]) begin
            r.valid_res   = 1'b1;
            r.instr_id    = w[10] ? ID_CALL : ID_GOTO;
            r.jump_target = w[9:0];
        end
        return r;
    endfunction

    function automatic dec_res_t decoded(input logic [6:0] id, input logic [9:0] tgt);
        dec_res_t r;
        r             = NO_INSTR;
        r.valid_res   = 1'b1;
        r.instr_id    = id;
        r.jump_target = tgt;
        return r;
    endfunction

    function automatic dir_row_t row_typed(input word_t w, input dec_res_t want);
        return {w, 1'b1, want};
    endfunction

    function automatic dir_row_t row_pred(input word_t w);
        return {w, 1'b0, NO_INSTR};
    endfunction

    function automatic word_t random_word();
        word_group_e grp;
        grp = word_group_e'($urandom_range(0, GRP_ANY + 1));
        if (grp > GRP_ANY)
            grp = GRP_ANY;
        case (grp)
            GRP_FIXED:    return word_t'($urandom_range(0, FIXED_LAST));
            GRP_IO_MOVE:  return IO_MOVE_FIRST + word_t'($urandom_range(0, 95));
            GRP_WORD_ACC: return WORD_ACC_FIRST + word_t'($urandom_range(0, 63));
            GRP_MEM_ALU:  return MEM_ALU_FIRST + word_t'($urandom_range(0, 13'h7FF));
            GRP_RET_K:    return RET_K_BASE | word_t'($urandom_range(0, 255));
            GRP_IMM:      return IMM_BASE | word_t'($urandom_range(0, 13'h7FF));
            GRP_MEM_BIT:  return MEM_BIT_BASE | word_t'($urandom_range(0, 13'h1FF));
            GRP_IO_BIT:   return IO_BIT_FIRST | word_t'($urandom_range(0, 13'h3FF));
            GRP_JUMP:     return JUMP_BASE | word_t'($urandom_range(0, 13'h7FF));
            default:      return word_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input int got_v, input int want_v,
                                 input word_t w);
        if (got_v != want_v)
            report_mismatch($sformatf("word %04h %s got %0h want %0h", w, name, got_v, want_v));
    endtask

    task automatic offer_word(input word_t w, input dec_res_t want, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_instr_word <= w;
        do @(posedge aclk); while (!s_ready);
        decode_due.push_back({w, want});
    endtask

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("mcu13_instruction_decoder_tb NOT OK");
            $finish;
        end
    end

    // Result side: random back-pressure with periodic stretches of none, one long hold-off, field checks.
    initial begin
        int          gap;
        int          beats;
        dec_res_t    seen;
        decode_due_t due;
        beats = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (beats == HOLD_AT_BEAT)
                gap = HOLD_CYCLES;
            else if ((beats / 96) % 4 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 19);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats++;
            seen = {m_valid_res, m_instr_id, m_mem_addr, m_io_addr, m_bit_index,
                    m_immediate, m_jump_target};
            if (decode_due.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, id %0d", seen.instr_id));
            end else begin
                due = decode_due.pop_front();
                compare_field("valid_res", seen.valid_res, due.want.valid_res, due.word);
                compare_field("instr_id", seen.instr_id, due.want.instr_id, due.word);
                compare_field("mem_addr", seen.mem_addr, due.want.mem_addr, due.word);
                compare_field("io_addr", seen.io_addr, due.want.io_addr, due.word);
                compare_field("bit_index", seen.bit_index, due.want.bit_index, due.word);
                compare_field("immediate", seen.immediate, due.want.immediate, due.word);
                compare_field("jump_target", seen.jump_target, due.want.jump_target,
                              due.word);
            end
        end
    end

    initial begin
        dir_row_t dir_rows [25];
        word_t    w;
        dir_rows = '{
            row_typed(13'h0000, decoded(ID_NOP, 10'd0)),
            row_typed(WORD_ALL_ONES, NO_INSTR),
            row_typed(13'h0001, NO_INSTR),
            row_typed(13'h0040, NO_INSTR),
            row_typed(13'h005F, NO_INSTR),
            row_typed(13'h0BC0, NO_INSTR),
            row_typed(13'h0BFF, NO_INSTR),
            row_typed(13'h1300, NO_INSTR),
            row_typed(13'h13FF, NO_INSTR),
            row_typed(13'h1800, decoded(ID_GOTO, 10'd0)),
            row_typed(13'h1FFE, decoded(ID_CALL, 10'h3FE)),
            row_pred(13'h003C),
            row_pred(13'h0060),
            row_pred(13'h00BF),
            row_pred(13'h00C0),
            row_pred(13'h00FF),
            row_pred(13'h0400),
            row_pred(13'h0BBF),
            row_pred(13'h01FF),
            row_pred(13'h1000),
            row_pred(13'h17FF),
            row_pred(13'h0200),
            row_pred(13'h03FF),
            row_pred(13'h0C00),
            row_pred(13'h0FFF)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            offer_word(dir_rows[i].word,
                       dir_rows[i].typed ? dir_rows[i].want : decode_word(dir_rows[i].word),
                       1'b0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == PAUSE_AT_WORD) begin
                s_valid <= 1'b0;
                while (decode_due.size() != 0) @(posedge aclk);
            end
            w = random_word();
            offer_word(w, decode_word(w), (n / 128) % 4 == 3);
        end
        s_valid <= 1'b0;

        while (decode_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("mcu13_instruction_decoder_tb OK");
        else
            $display("mcu13_instruction_decoder_tb NOT OK");
        $finish;
    end

endmodule
